[hdl/shd_pkg.sv]
package shd_pkg;

  localparam logic [7:0] SyncOne       = 8'h75;
  localparam logic [7:0] SyncTwo       = 8'h65;
  localparam logic [7:0] FieldOverhead = 8'd2;

  typedef enum logic [2:0] {
    PhHunt,
    PhFlen,
    PhFdesc,
    PhFdata,
    PhSkip,
    PhChkh,
    PhChkl
  } phase_e;

  typedef enum logic [1:0] {
    KindData      = 2'd0,
    KindGood      = 2'd1,
    KindCsumBad   = 2'd2,
    KindMalformed = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  hdr_set;
    logic [6:0]  field_number;
    logic [7:0]  field_descriptor;
    logic [7:0]  field_data_length;
    logic [7:0]  data_offset;
    logic [7:0]  data_byte;
    logic        last_in_field;
    logic [6:0]  field_count;
    logic [15:0] computed_sum;
    logic [15:0] received_sum;
  } result_t;

endpackage

[hdl/shd_parser.sv]
module shd_parser import shd_pkg::*; #(
  parameter int FieldLimit = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] win_q [3];
  logic [7:0] win_d [3];
  logic [1:0] fill_q, fill_d;
  logic [7:0] set_q, set_d;
  logic [7:0] pay_left_q, pay_left_d;
  logic [7:0] s1_q, s1_d;
  logic [7:0] s2_q, s2_d;
  logic [7:0] fleft_q, fleft_d;
  logic [6:0] fcnt_q, fcnt_d;
  logic [7:0] desc_q, desc_d;
  logic [7:0] len_q, len_d;
  logic [7:0] off_q, off_d;
  logic [7:0] rhigh_q, rhigh_d;
  logic       bad_q, bad_d;

  logic [7:0]  h1, h2, h3, h4;
  logic [7:0]  g1, g2, g3, g4;
  logic [7:0]  p1, p2;
  logic [7:0]  fleft_dec;
  logic [7:0]  pay_dec;
  logic [15:0] computed;
  logic [15:0] received;
  logic        sync_ok;

  // Header checksum: four chained byte sums starting from zero
  always_comb begin
    h1 = win_q[0];
    g1 = h1;
    h2 = h1 + win_q[1];
    g2 = g1 + h2;
    h3 = h2 + win_q[2];
    g3 = g2 + h3;
    h4 = h3 + rx_byte_i;
    g4 = g3 + h4;
  end

  assign p1        = s1_q + rx_byte_i;
  assign p2        = s2_q + p1;
  assign fleft_dec = fleft_q - 8'd1;
  assign pay_dec   = pay_left_q - 8'd1;
  assign computed  = {s1_q, s2_q};
  assign received  = {rhigh_q, rx_byte_i};
  assign sync_ok   = (win_q[0] == SyncOne) && (win_q[1] == SyncTwo);

  always_comb begin
    phase_d    = phase_q;
    win_d      = win_q;
    fill_d     = fill_q;
    set_d      = set_q;
    pay_left_d = pay_left_q;
    s1_d       = s1_q;
    s2_d       = s2_q;
    fleft_d    = fleft_q;
    fcnt_d     = fcnt_q;
    desc_d     = desc_q;
    len_d      = len_q;
    off_d      = off_q;
    rhigh_d    = rhigh_q;
    bad_d      = bad_q;
    if (byte_valid_i) begin
      case (phase_q)
        PhHunt: begin
          if (fill_q != 2'd3) begin
            win_d[fill_q] = rx_byte_i;
            fill_d        = fill_q + 2'd1;
          end else if (!sync_ok) begin
            // slide the window by one byte
            win_d[0] = win_q[1];
            win_d[1] = win_q[2];
            win_d[2] = rx_byte_i;
          end else begin
            set_d      = win_q[2];
            pay_left_d = rx_byte_i;
            s1_d       = h4;
            s2_d       = g4;
            fcnt_d     = '0;
            fleft_d    = '0;
            off_d      = '0;
            len_d      = '0;
            desc_d     = '0;
            bad_d      = 1'b0;
            fill_d     = '0;
            phase_d    = (rx_byte_i == 8'd0) ? PhChkh : PhFlen;
          end
        end
        PhChkh: begin
          rhigh_d = rx_byte_i;
          phase_d = PhChkl;
        end
        PhChkl: begin
          fill_d  = '0;
          phase_d = PhHunt;
        end
        default: begin
          s1_d = p1;
          s2_d = p2;
          case (phase_q)
            PhFlen: begin
              if (rx_byte_i < FieldOverhead || rx_byte_i > pay_left_q ||
                  fcnt_q >= 7'(FieldLimit)) begin
                bad_d   = 1'b1;
                phase_d = PhSkip;
              end else begin
                len_d   = rx_byte_i;
                fleft_d = rx_byte_i - FieldOverhead;
                phase_d = PhFdesc;
              end
            end
            PhFdesc: begin
              desc_d = rx_byte_i;
              off_d  = '0;
              if (fleft_q == 8'd0) begin
                fcnt_d  = fcnt_q + 7'd1;
                phase_d = PhFlen;
              end else begin
                phase_d = PhFdata;
              end
            end
            PhFdata: begin
              off_d   = off_q + 8'd1;
              fleft_d = fleft_dec;
              if (fleft_dec == 8'd0) begin
                fcnt_d  = fcnt_q + 7'd1;
                phase_d = PhFlen;
              end
            end
            default: phase_d = PhSkip;
          endcase
          pay_left_d = pay_dec;
          if (pay_dec == 8'd0) phase_d = PhChkh;
        end
      endcase
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.hdr_set = set_q;
    case (phase_q)
      PhFdata: begin
        res_valid_o             = byte_valid_i;
        res_o.kind              = KindData;
        res_o.field_number      = fcnt_q;
        res_o.field_descriptor  = desc_q;
        res_o.field_data_length = len_q - FieldOverhead;
        res_o.data_offset       = off_q;
        res_o.data_byte         = rx_byte_i;
        res_o.last_in_field     = (fleft_q == 8'd1);
      end
      PhChkl: begin
        res_valid_o        = byte_valid_i;
        res_o.field_count  = fcnt_q;
        res_o.computed_sum = computed;
        res_o.received_sum = received;
        if (computed != received) begin
          res_o.kind = KindCsumBad;
        end else if (bad_q) begin
          res_o.kind = KindMalformed;
        end else begin
          res_o.kind = KindGood;
        end
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHunt;
      win_q[0]   <= '0;
      win_q[1]   <= '0;
      win_q[2]   <= '0;
      fill_q     <= '0;
      set_q      <= '0;
      pay_left_q <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      fleft_q    <= '0;
      fcnt_q     <= '0;
      desc_q     <= '0;
      len_q      <= '0;
      off_q      <= '0;
      rhigh_q    <= '0;
      bad_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      win_q      <= win_d;
      fill_q     <= fill_d;
      set_q      <= set_d;
      pay_left_q <= pay_left_d;
      s1_q       <= s1_d;
      s2_q       <= s2_d;
      fleft_q    <= fleft_d;
      fcnt_q     <= fcnt_d;
      desc_q     <= desc_d;
      len_q      <= len_d;
      off_q      <= off_d;
      rhigh_q    <= rhigh_d;
      bad_q      <= bad_d;
    end
  end

endmodule

[hdl/shd_fifo.sv]
module shd_fifo import shd_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wdata_i,
  output logic    full_o,
  input  logic    rd_i,
  output logic    empty_o,
  output result_t rdata_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      if (do_rd) rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[hdl/sync_header_packet_deframer_core.sv]
// Results: a result enters the output queue at the edge that takes its byte and,
// once at the head of the queue, is on the result ports and can be popped.
// Throughput: one byte per cycle; push stalls only while the result queue
// (QueueDepth entries) is full.
// Reset: rst_ni is asynchronous, active low; the parser returns to header hunt
// with an empty window and the result queue empties.
module sync_header_packet_deframer_core import shd_pkg::*; #(
  parameter int FieldLimit = 16,
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  descriptor_set_o,
  output logic [6:0]  field_number_o,
  output logic [7:0]  field_descriptor_o,
  output logic [7:0]  field_data_length_o,
  output logic [7:0]  data_offset_o,
  output logic [7:0]  data_byte_o,
  output logic        last_in_field_o,
  output logic [6:0]  field_count_o,
  output logic [15:0] computed_sum_o,
  output logic [15:0] received_sum_o
);

  logic    byte_valid;
  logic    res_valid;
  result_t res;
  result_t head;

  // hold input whenever the queue cannot take a possible result
  assign byte_valid = push && !full;

  shd_parser #(
    .FieldLimit(FieldLimit)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  shd_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_valid),
    .wdata_i(res),
    .full_o (full),
    .rd_i   (pop),
    .empty_o(empty),
    .rdata_o(head)
  );

  assign kind_o              = head.kind;
  assign descriptor_set_o    = head.hdr_set;
  assign field_number_o      = head.field_number;
  assign field_descriptor_o  = head.field_descriptor;
  assign field_data_length_o = head.field_data_length;
  assign data_offset_o       = head.data_offset;
  assign data_byte_o         = head.data_byte;
  assign last_in_field_o     = head.last_in_field;
  assign field_count_o       = head.field_count;
  assign computed_sum_o      = head.computed_sum;
  assign received_sum_o      = head.received_sum;

endmodule

[bench/tb_sync_header_packet_deframer_core.sv]
module tb_sync_header_packet_deframer_core;
  import shd_pkg::*;

  localparam int FieldLimit  = 16;
  localparam int StreamBytes = 1850;
  localparam int StallLimit  = 2000;
  localparam int TailCycles  = 20;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  kind_o;
  logic [7:0]  descriptor_set_o;
  logic [6:0]  field_number_o;
  logic [7:0]  field_descriptor_o;
  logic [7:0]  field_data_length_o;
  logic [7:0]  data_offset_o;
  logic [7:0]  data_byte_o;
  logic        last_in_field_o;
  logic [6:0]  field_count_o;
  logic [15:0] computed_sum_o;
  logic [15:0] received_sum_o;

  sync_header_packet_deframer_core #(
    .FieldLimit(FieldLimit)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte_i),
    .empty              (empty),
    .pop                (pop),
    .kind_o             (kind_o),
    .descriptor_set_o   (descriptor_set_o),
    .field_number_o     (field_number_o),
    .field_descriptor_o (field_descriptor_o),
    .field_data_length_o(field_data_length_o),
    .data_offset_o      (data_offset_o),
    .data_byte_o        (data_byte_o),
    .last_in_field_o    (last_in_field_o),
    .field_count_o      (field_count_o),
    .computed_sum_o     (computed_sum_o),
    .received_sum_o     (received_sum_o)
  );

  always #10 clk_i = ~clk_i;

  // Byte stream waiting to be pushed, and the deframer results it must produce.
  logic [7:0]  rx_stream[$];
  logic [7:0]  payload_bytes[$];
  result_t     pending_results[$];
  result_t     want;

  // Shadow deframer state.
  phase_e      ph           = PhHunt;
  logic [7:0]  win[3]       = '{8'h00, 8'h00, 8'h00};
  logic [2:0]  win_fill     = '0;
  logic [7:0]  pkt_set      = '0;
  logic [7:0]  payload_left = '0;
  logic [7:0]  run_a        = '0;
  logic [7:0]  run_b        = '0;
  logic [7:0]  field_left   = '0;
  logic [6:0]  field_num    = '0;
  logic [7:0]  field_desc   = '0;
  logic [7:0]  field_len    = '0;
  logic [7:0]  data_pos     = '0;
  logic [7:0]  carried_high = '0;
  logic        malformed    = 1'b0;

  int unsigned send_gap = 0, send_calm = 0, recv_gap = 0, recv_calm = 0;
  int unsigned quiet_cycles = 0, bytes_taken = 0, fail_count = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};

  function automatic int unsigned idle_gap(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 199);
    if (calm != 0) begin
      calm--;
      idle_gap = 0;
    end else if (r == 0) begin
      calm = $urandom_range(100, 300);
      idle_gap = 0;
    end else if (r < 110) idle_gap = 0;
    else if (r < 170) idle_gap = $urandom_range(1, 3);
    else if (r < 195) idle_gap = $urandom_range(4, 12);
    else idle_gap = $urandom_range(20, 60);
  endfunction

  task automatic fold_sum(input logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
  endtask

  // Advance the shadow deframer by one accepted byte.
  task automatic advance_deframer(input logic [7:0] b);
    result_t r;
    r = '0;
    case (ph)
      PhHunt: begin
        if (win_fill < 3) begin
          win[win_fill] = b;
          win_fill++;
        end else if (win[0] != SyncOne || win[1] != SyncTwo) begin
          win[0] = win[1];
          win[1] = win[2];
          win[2] = b;
        end else begin
          pkt_set      = win[2];
          payload_left = b;
          run_a        = '0;
          run_b        = '0;
          fold_sum(win[0]);
          fold_sum(win[1]);
          fold_sum(win[2]);
          fold_sum(b);
          field_num    = '0;
          field_left   = '0;
          data_pos     = '0;
          field_len    = '0;
          field_desc   = '0;
          malformed    = 1'b0;
          win_fill     = '0;
          ph = (b == 8'd0) ? PhChkh : PhFlen;
        end
      end
      PhChkh: begin
        carried_high = b;
        ph = PhChkl;
      end
      PhChkl: begin
        r.computed_sum   = {run_a, run_b};
        r.received_sum   = {carried_high, b};
        r.hdr_set        = pkt_set;
        r.field_count    = field_num;
        if (r.computed_sum != r.received_sum) r.kind = KindCsumBad;
        else if (malformed) r.kind = KindMalformed;
        else r.kind = KindGood;
        pending_results.push_back(r);
        win_fill = '0;
        ph = PhHunt;
      end
      default: begin
        fold_sum(b);
        case (ph)
          PhFlen: begin
            if (b < FieldOverhead || b > payload_left || field_num >= FieldLimit) begin
              malformed = 1'b1;
              ph = PhSkip;
            end else begin
              field_len  = b;
              field_left = b - FieldOverhead;
              ph = PhFdesc;
            end
          end
          PhFdesc: begin
            field_desc = b;
            data_pos   = '0;
            if (field_left == 0) begin
              field_num++;
              ph = PhFlen;
            end else begin
              ph = PhFdata;
            end
          end
          PhFdata: begin
            r.kind              = KindData;
            r.hdr_set           = pkt_set;
            r.field_number      = field_num;
            r.field_descriptor  = field_desc;
            r.field_data_length = field_len - FieldOverhead;
            r.data_offset       = data_pos;
            r.data_byte         = b;
            r.last_in_field     = (field_left == 8'd1);
            pending_results.push_back(r);
            data_pos++;
            field_left--;
            if (field_left == 0) begin
              field_num++;
              ph = PhFlen;
            end
          end
          default: ph = PhSkip;
        endcase
        payload_left--;
        if (payload_left == 0) ph = PhChkh;
      end
    endcase
  endtask

  task automatic add_field(input logic [7:0] len);
    payload_bytes.push_back(len);
    payload_bytes.push_back(8'($urandom_range(0, 255)));
    for (int k = 2; k < len; k++) payload_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Frame payload_bytes with header and checksum and append it to the stream.
  task automatic queue_packet(input logic [7:0] set_byte, input bit spoil_sum);
    logic [7:0] frame[$];
    logic [7:0] sa, sb;
    frame.push_back(SyncOne);
    frame.push_back(SyncTwo);
    frame.push_back(set_byte);
    frame.push_back(8'(payload_bytes.size()));
    foreach (payload_bytes[k]) frame.push_back(payload_bytes[k]);
    sa = '0;
    sb = '0;
    foreach (frame[k]) begin
      sa = sa + frame[k];
      sb = sb + sa;
    end
    if (spoil_sum) begin
      if ($urandom_range(0, 1) == 1) sa = sa ^ 8'($urandom_range(1, 255));
      else sb = sb ^ 8'($urandom_range(1, 255));
    end
    frame.push_back(sa);
    frame.push_back(sb);
    foreach (frame[k]) rx_stream.push_back(frame[k]);
    payload_bytes.delete();
  endtask

  task automatic queue_random_packet();
    int unsigned mode, nf, room;
    mode = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
    if (mode >= 96) begin
      // broken header: sync byte followed by junk
      rx_stream.push_back(SyncOne);
      repeat ($urandom_range(0, 6)) rx_stream.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (mode < 3) begin
        add_field(8'd255);
      end else begin
        nf = (mode < 9) ? $urandom_range(15, 18) : $urandom_range(0, 5);
        repeat (nf) add_field(8'($urandom_range(2, 9)));
        if (mode >= 70 && mode < 78) begin
          payload_bytes.push_back(8'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 4)) payload_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (mode >= 78 && mode < 86) begin
          room = $urandom_range(1, 6);
          payload_bytes.push_back(8'($urandom_range(room + 1, 255)));
          repeat (room - 1) payload_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      queue_packet(8'($urandom_range(0, 255)), (mode >= 86) || ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Driver: push bytes from rx_stream with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        advance_deframer(rx_byte_i);
        bytes_taken++;
        send_gap = idle_gap(send_calm);
      end
      if (push && full) begin
        // hold the byte until accepted
      end else if (send_gap != 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (rx_stream.size() != 0) begin
        push      <= 1'b1;
        rx_byte_i <= rx_stream.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pop results with random stalls and compare each transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d, set %0d", kind_o, descriptor_set_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("descriptor_set", want.hdr_set, descriptor_set_o);
          check_field("field_number", want.field_number, field_number_o);
          check_field("field_descriptor", want.field_descriptor, field_descriptor_o);
          check_field("field_data_length", want.field_data_length, field_data_length_o);
          check_field("data_offset", want.data_offset, data_offset_o);
          check_field("data_byte", want.data_byte, data_byte_o);
          check_field("last_in_field", want.last_in_field, last_in_field_o);
          check_field("field_count", want.field_count, field_count_o);
          check_field("computed_sum", want.computed_sum, computed_sum_o);
          check_field("received_sum", want.received_sum, received_sum_o);
          kind_seen[want.kind]++;
        end
        recv_gap = idle_gap(recv_calm);
      end
      if (recv_gap != 0) begin
        pop <= 1'b0;
        recv_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    // Bad sync: the leading pair forces the window to slide.
    rx_stream.push_back(SyncOne);
    rx_stream.push_back(SyncOne);
    // Empty payload, all-ones set.
    queue_packet(8'hFF, 1'b0);
    // Field with no data, then a one-byte field.
    payload_bytes.push_back(8'd2);
    payload_bytes.push_back(8'hFF);
    payload_bytes.push_back(8'd3);
    payload_bytes.push_back(8'h00);
    payload_bytes.push_back(8'hFF);
    queue_packet(8'h00, 1'b0);
    // Field length below two.
    payload_bytes.push_back(8'd1);
    payload_bytes.push_back(8'hA5);
    payload_bytes.push_back(8'h5A);
    queue_packet(8'h5A, 1'b0);
    // Field running past the payload, with a bad checksum on top.
    payload_bytes.push_back(8'd5);
    payload_bytes.push_back(8'h11);
    payload_bytes.push_back(8'h22);
    queue_packet(8'h33, 1'b1);
    // Checksum bad on an otherwise clean packet.
    queue_packet(8'h81, 1'b1);

    while (rx_stream.size() < StreamBytes) queue_random_packet();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_stream.size() != 0 || push || pending_results.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (!empty) begin
      $error("result left in the output queue with nothing expected");
      fail_count++;
    end

    $display("Pushed %0d bytes; checked %0d field data bytes and %0d verdicts",
             bytes_taken, kind_seen[KindData],
             kind_seen[KindGood] + kind_seen[KindCsumBad] + kind_seen[KindMalformed]);
    $display("Verdicts: %0d good, %0d checksum bad, %0d malformed; %0d mismatches",
             kind_seen[KindGood], kind_seen[KindCsumBad], kind_seen[KindMalformed],
             fail_count);
    if (fail_count == 0 && pending_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
